// ===== rtl/cstk_pkg.sv =====
package cstk_pkg;

  localparam int unsigned SLOTS   = 64;
  localparam int unsigned IDW     = 6;
  localparam int unsigned TW      = 48;
  localparam int unsigned NW      = 32;
  localparam int unsigned CW      = 7;
  localparam int unsigned QDEPTH  = 2;

  localparam logic [CW-1:0] SLOT_LIMIT_RST    = 7'd64;
  localparam logic [TW-1:0] TIMEOUT_LIMIT_RST = 48'd30000;
  localparam logic [TW-1:0] PING_INTERVAL_RST = 48'd5000;
  localparam logic [CW-1:0] COUNT_MAX         = 7'd127;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_REMOVE   = 4'd1,
    OP_QUERY    = 4'd2,
    OP_SET      = 4'd3,
    OP_ACTIVITY = 4'd4,
    OP_PING     = 4'd5,
    OP_PONG     = 4'd6,
    OP_CHECK    = 4'd7,
    OP_FIND     = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE       = 2'd0,
    ST_CONNECTING = 2'd1,
    ST_CONNECTED  = 2'd2,
    ST_BAD        = 2'd3
  } slot_st_e;

  typedef enum logic [1:0] {
    REG_SLOT_LIMIT    = 2'd0,
    REG_TIMEOUT_LIMIT = 2'd1,
    REG_PING_INTERVAL = 2'd2
  } reg_e;

  // classified item passed from front to back
  typedef struct packed {
    logic [3:0]     op;
    logic           id_ok;
    logic [IDW-1:0] peer_id;
    logic [TW-1:0]  time_now;
    logic [NW-1:0]  nonce;
    logic [1:0]     new_state;
  } cmd_t;

endpackage

// ===== rtl/cstk_front.sv =====
module cstk_front
  import cstk_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [3:0]     op_i,
  input  logic [IDW-1:0] peer_id_i,
  input  logic [TW-1:0]  time_now_i,
  input  logic [NW-1:0]  nonce_i,
  input  logic [1:0]     new_state_i,
  input  logic [CW-1:0]  lim_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output cmd_t           cmd_o
);

  cmd_t           q_mem_q [QDEPTH];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;
  cmd_t           c;
  logic           push, pop;

  assign in_ready_o  = (cnt_q != 2'(QDEPTH));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    c.op        = op_i;
    c.id_ok     = ({1'b0, peer_id_i} < lim_i);
    c.peer_id   = peer_id_i;
    c.time_now  = time_now_i;
    c.nonce     = nonce_i;
    c.new_state = new_state_i;
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= c;
  end

endmodule

// ===== rtl/cstk_back.sv =====
module cstk_back
  import cstk_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  cmd_t           cmd_i,
  input  logic [CW-1:0]  lim_i,
  input  logic [TW-1:0]  timeout_limit_i,
  input  logic [TW-1:0]  ping_interval_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           ok_o,
  output logic           found_o,
  output logic [IDW-1:0] slot_index_o,
  output logic [1:0]     slot_state_o,
  output logic [NW-1:0]  round_trip_o,
  output logic           timed_out_o,
  output logic           needs_ping_o,
  output logic [NW-1:0]  stored_nonce_o,
  output logic [CW-1:0]  active_count_o
);

  // per-slot state in flops; valid bits give reset value for the wide fields
  logic [1:0]    status_q [SLOTS];
  logic          vld_q    [SLOTS];
  logic          pinged_q [SLOTS];
  logic [TW-1:0] act_q    [SLOTS];
  logic [TW-1:0] ping_q   [SLOTS];
  logic [NW-1:0] nonce_q  [SLOTS];
  logic [NW-1:0] rtt_q    [SLOTS];
  logic [CW-1:0] total_q, total_d;

  // stage register: item latched, read data, then execute
  logic          busy_q, busy_d;
  cmd_t          c_q;
  logic [1:0]    r_st_q;
  logic          r_pinged_q;
  logic [TW-1:0] r_act_q, r_ping_q;
  logic [NW-1:0] r_nonce_q, r_rtt_q;
  logic          ff_found_q;
  logic [IDW-1:0] ff_idx_q;

  logic          ovalid_q;
  logic          ok_q, found_q, tmo_q, np_q;
  logic [IDW-1:0] idx_q;
  logic [1:0]    st_q;
  logic [NW-1:0] rtt_o_q, sn_q;

  logic          take, fire;
  logic [SLOTS-1:0] free_vec;
  logic          ff_found;
  logic [IDW-1:0] ff_idx;
  logic [IDW-1:0] rd_id;
  logic          vsel;

  logic          ok_d, found_d, tmo_d, np_d;
  logic [IDW-1:0] idx_d;
  logic [1:0]    st_d;
  logic [NW-1:0] rtt_d, sn_d;
  logic          wr_add, wr_rem, wr_set, wr_act, wr_ping, wr_pong;
  logic [TW:0]   d_act, d_ping;

  assign cmd_ready_o = !busy_q;
  assign take        = cmd_valid_i && !busy_q;
  assign fire        = busy_q && (!ovalid_q || out_ready_i);
  // find free reads the slot it found, every other op the addressed one
  assign rd_id       = (cmd_i.op == OP_FIND) ? ff_idx : cmd_i.peer_id;
  assign vsel        = vld_q[rd_id];

  // first free slot below the limit
  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      free_vec[i] = (status_q[i] == ST_FREE) && (CW'(i) < lim_i);
      if (free_vec[i]) begin
        ff_found = 1'b1;
        ff_idx   = IDW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else         busy_q <= busy_d;
  end

  always_comb busy_d = take ? 1'b1 : (fire ? 1'b0 : busy_q);

  always_ff @(posedge clk_i) begin
    if (take) begin
      c_q        <= cmd_i;
      r_st_q     <= status_q[rd_id];
      r_pinged_q <= pinged_q[rd_id];
      r_act_q    <= vsel ? act_q[rd_id]   : '0;
      r_ping_q   <= vsel ? ping_q[rd_id]  : '0;
      r_nonce_q  <= vsel ? nonce_q[rd_id] : '0;
      r_rtt_q    <= vsel ? rtt_q[rd_id]   : '0;
      ff_found_q <= ff_found;
      ff_idx_q   <= ff_idx;
    end
  end

  // execute
  always_comb begin
    ok_d = 1'b0; found_d = 1'b0; idx_d = c_q.peer_id; st_d = ST_FREE;
    rtt_d = '0; tmo_d = 1'b0; np_d = 1'b0; sn_d = '0;
    wr_add = 1'b0; wr_rem = 1'b0; wr_set = 1'b0;
    wr_act = 1'b0; wr_ping = 1'b0; wr_pong = 1'b0;
    total_d = total_q;
    d_act  = {1'b0, c_q.time_now} - {1'b0, r_act_q};
    d_ping = {1'b0, c_q.time_now} - {1'b0, r_ping_q};
    if (c_q.op == OP_FIND) begin
      idx_d = '0;
      if (ff_found_q) begin
        ok_d = 1'b1; found_d = 1'b1; idx_d = ff_idx_q;
        st_d = ST_FREE; sn_d = r_nonce_q;
      end
    end else if (c_q.op <= OP_CHECK && c_q.id_ok) begin
      ok_d = 1'b1;
      st_d = r_st_q;
      sn_d = r_nonce_q;
      case (c_q.op)
        OP_ADD: begin
          if (r_st_q != ST_FREE) ok_d = 1'b0;
          else begin
            wr_add = 1'b1; st_d = ST_CONNECTING; sn_d = '0;
            if (total_q < COUNT_MAX) total_d = total_q + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (r_st_q == ST_FREE) ok_d = 1'b0;
          else begin
            wr_rem = 1'b1; st_d = ST_FREE; sn_d = '0;
            if (total_q != '0) total_d = total_q - 1'b1;
          end
        end
        OP_QUERY: begin
          found_d = (r_st_q != ST_FREE);
          rtt_d   = r_rtt_q;
        end
        OP_SET: begin
          if (c_q.new_state == ST_BAD) ok_d = 1'b0;
          else begin
            wr_set = 1'b1; st_d = c_q.new_state;
          end
        end
        OP_ACTIVITY: wr_act = 1'b1;
        OP_PING: begin
          wr_ping = 1'b1; sn_d = c_q.nonce;
        end
        OP_PONG: begin
          if (d_ping[TW]) ok_d = 1'b0;
          else begin
            wr_pong = 1'b1; rtt_d = d_ping[NW-1:0];
          end
        end
        default: begin
          if (r_st_q != ST_FREE && !d_act[TW])
            tmo_d = (d_act[TW-1:0] > timeout_limit_i);
          if (r_st_q == ST_CONNECTED) begin
            if (!r_pinged_q || d_ping[TW]) np_d = 1'b1;
            else np_d = (d_ping[TW-1:0] >= ping_interval_i);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        status_q[i] <= ST_FREE;
        vld_q[i]    <= 1'b0;
        pinged_q[i] <= 1'b0;
      end
    end else begin
      if (fire) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      if (fire) begin
        total_q <= total_d;
        if (wr_add) begin
          status_q[c_q.peer_id] <= ST_CONNECTING;
          vld_q[c_q.peer_id]    <= 1'b0;
          pinged_q[c_q.peer_id] <= 1'b0;
        end
        if (wr_rem) begin
          status_q[c_q.peer_id] <= ST_FREE;
          vld_q[c_q.peer_id]    <= 1'b0;
          pinged_q[c_q.peer_id] <= 1'b0;
        end
        if (wr_set) status_q[c_q.peer_id] <= c_q.new_state;
        if (wr_act || wr_ping || wr_pong) vld_q[c_q.peer_id] <= 1'b1;
        if (wr_ping) pinged_q[c_q.peer_id] <= 1'b1;
      end
    end
  end

  // payload writes; the whole entry is rewritten on every payload write, also when it first becomes valid
  always_ff @(posedge clk_i) begin
    if (fire && (wr_act || wr_ping || wr_pong)) begin
      act_q[c_q.peer_id]   <= wr_act  ? c_q.time_now : r_act_q;
      ping_q[c_q.peer_id]  <= wr_ping ? c_q.time_now : r_ping_q;
      nonce_q[c_q.peer_id] <= wr_ping ? c_q.nonce    : r_nonce_q;
      rtt_q[c_q.peer_id]   <= wr_pong ? d_ping[NW-1:0] : r_rtt_q;
    end
    if (fire) begin
      ok_q <= ok_d; found_q <= found_d; idx_q <= idx_d; st_q <= st_d;
      rtt_o_q <= rtt_d; tmo_q <= tmo_d; np_q <= np_d; sn_q <= sn_d;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign ok_o           = ok_q;
  assign found_o        = found_q;
  assign slot_index_o   = idx_q;
  assign slot_state_o   = st_q;
  assign round_trip_o   = rtt_o_q;
  assign timed_out_o    = tmo_q;
  assign needs_ping_o   = np_q;
  assign stored_nonce_o = sn_q;
  assign active_count_o = total_q;

endmodule

// ===== rtl/connection_slot_table_keepalive.sv =====
// connection slot table with keepalive timing
// path: an input beat passes the queue, the slot read and the execute result register to its result beat
// the back end takes a new item only once the last one's read then update of one slot is done
// reset: rst_ni clears all slots to disconnected, the count, queue and output valid
// registers reset to slot_limit 64, timeout 30000 ms, ping interval 5000 ms
module connection_slot_table_keepalive
  import cstk_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [TW-1:0]  cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [3:0]     op_i,
  input  logic [IDW-1:0] peer_id_i,
  input  logic [TW-1:0]  time_now_i,
  input  logic [NW-1:0]  nonce_i,
  input  logic [1:0]     new_state_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           ok_o,
  output logic           found_o,
  output logic [IDW-1:0] slot_index_o,
  output logic [1:0]     slot_state_o,
  output logic [NW-1:0]  round_trip_o,
  output logic           timed_out_o,
  output logic           needs_ping_o,
  output logic [NW-1:0]  stored_nonce_o,
  output logic [CW-1:0]  active_count_o
);

  logic [CW-1:0] slot_limit_q;
  logic [TW-1:0] timeout_limit_q, ping_interval_q;
  logic [CW-1:0] lim;
  logic          cmd_valid, cmd_ready;
  cmd_t          cmd;

  // usable slots: limit clamped to table size
  assign lim = (slot_limit_q > CW'(SLOTS)) ? CW'(SLOTS) : slot_limit_q;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q    <= SLOT_LIMIT_RST;
      timeout_limit_q <= TIMEOUT_LIMIT_RST;
      ping_interval_q <= PING_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SLOT_LIMIT:    slot_limit_q    <= cfg_data_i[CW-1:0];
        REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data_i;
        REG_PING_INTERVAL: ping_interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: id check and a two-entry queue
  cstk_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .peer_id_i,
    .time_now_i, .nonce_i, .new_state_i,
    .lim_i       (lim),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back: slot read, execute, result register
  cstk_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .lim_i           (lim),
    .timeout_limit_i (timeout_limit_q),
    .ping_interval_i (ping_interval_q),
    .out_valid_o, .out_ready_i, .ok_o, .found_o, .slot_index_o, .slot_state_o,
    .round_trip_o, .timed_out_o, .needs_ping_o, .stored_nonce_o, .active_count_o
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cstk_pkg::*;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // configuration port
  logic           cfg_we_i = 1'b0;
  logic [1:0]     cfg_index_i = '0;
  logic [TW-1:0]  cfg_data_i = '0;

  // request channel
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  logic [3:0]     op_i = '0;
  logic [IDW-1:0] peer_id_i = '0;
  logic [TW-1:0]  time_now_i = '0;
  logic [NW-1:0]  nonce_i = '0;
  logic [1:0]     new_state_i = '0;

  // response channel
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  logic           ok_o;
  logic           found_o;
  logic [IDW-1:0] slot_index_o;
  logic [1:0]     slot_state_o;
  logic [NW-1:0]  round_trip_o;
  logic           timed_out_o;
  logic           needs_ping_o;
  logic [NW-1:0]  stored_nonce_o;
  logic [CW-1:0]  active_count_o;

  connection_slot_table_keepalive dut (.*);

  typedef struct packed {
    logic           ok;
    logic           found;
    logic [IDW-1:0] slot_index;
    logic [1:0]     slot_state;
    logic [NW-1:0]  round_trip;
    logic           timed_out;
    logic           needs_ping;
    logic [NW-1:0]  stored_nonce;
    logic [CW-1:0]  active_count;
  } reply_t;

  typedef struct packed {
    logic [3:0]     op;
    logic [IDW-1:0] peer_id;
    logic [TW-1:0]  time_now;
    logic [NW-1:0]  nonce;
    logic [1:0]     new_state;
  } request_t;

  // shadow copy of the slot table
  slot_st_e       sh_status [SLOTS];
  logic [TW-1:0]  sh_activity [SLOTS];
  logic [TW-1:0]  sh_ping_time [SLOTS];
  logic           sh_pinged [SLOTS];
  logic [NW-1:0]  sh_nonce [SLOTS];
  logic [NW-1:0]  sh_rtt [SLOTS];
  logic [CW-1:0]  sh_active;
  logic [CW-1:0]  sh_slot_limit;
  logic [TW-1:0]  sh_timeout;
  logic [TW-1:0]  sh_interval;

  reply_t expected_replies[$];
  bit     failed = 1'b0;
  int     cycles = 0;
  bit     out_hold = 1'b0;

  function automatic void wipe_slot(int i);
    sh_status[i] = ST_FREE;
    sh_activity[i] = '0;
    sh_ping_time[i] = '0;
    sh_pinged[i] = 1'b0;
    sh_nonce[i] = '0;
    sh_rtt[i] = '0;
  endfunction

  // next state and reply of the slot table for one request
  function automatic reply_t table_step(request_t rq);
    reply_t r;
    int lim;
    int id;
    r = '0;
    r.slot_index = rq.peer_id;
    id = rq.peer_id;
    lim = (sh_slot_limit > SLOTS) ? SLOTS : sh_slot_limit;
    if (rq.op == OP_FIND) begin
      r.slot_index = '0;
      for (int i = 0; i < lim; i++) begin
        if (sh_status[i] == ST_FREE) begin
          r.ok = 1'b1;
          r.found = 1'b1;
          r.slot_index = IDW'(i);
          r.stored_nonce = sh_nonce[i];
          break;
        end
      end
    end else if (rq.op <= OP_CHECK && id < lim) begin
      r.ok = 1'b1;
      case (op_e'(rq.op))
        OP_ADD: begin
          if (sh_status[id] != ST_FREE) begin
            r.ok = 1'b0;
          end else begin
            wipe_slot(id);
            sh_status[id] = ST_CONNECTING;
            if (sh_active < COUNT_MAX) sh_active++;
          end
        end
        OP_REMOVE: begin
          if (sh_status[id] == ST_FREE) begin
            r.ok = 1'b0;
          end else begin
            wipe_slot(id);
            if (sh_active > 0) sh_active--;
          end
        end
        OP_QUERY: begin
          r.found = sh_status[id] != ST_FREE;
          r.round_trip = sh_rtt[id];
        end
        OP_SET: begin
          if (rq.new_state > ST_CONNECTED) r.ok = 1'b0;
          else sh_status[id] = slot_st_e'(rq.new_state);
        end
        OP_ACTIVITY: sh_activity[id] = rq.time_now;
        OP_PING: begin
          sh_ping_time[id] = rq.time_now;
          sh_pinged[id] = 1'b1;
          sh_nonce[id] = rq.nonce;
        end
        OP_PONG: begin
          if (rq.time_now < sh_ping_time[id]) begin
            r.ok = 1'b0;
          end else begin
            sh_rtt[id] = NW'(rq.time_now - sh_ping_time[id]);
            r.round_trip = sh_rtt[id];
          end
        end
        default: begin
          if (sh_status[id] != ST_FREE && rq.time_now >= sh_activity[id])
            r.timed_out = (rq.time_now - sh_activity[id]) > sh_timeout;
          if (sh_status[id] == ST_CONNECTED) begin
            if (!sh_pinged[id] || rq.time_now < sh_ping_time[id]) r.needs_ping = 1'b1;
            else r.needs_ping = (rq.time_now - sh_ping_time[id]) >= sh_interval;
          end
        end
      endcase
      r.slot_state = sh_status[id];
      r.stored_nonce = sh_nonce[id];
    end
    r.active_count = sh_active;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // response side: random back-pressure, check each beat against the oldest entry
  always @(posedge clk_i) begin
    reply_t got;
    reply_t exp;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{ok_o, found_o, slot_index_o, slot_state_o, round_trip_o, timed_out_o,
                needs_ping_o, stored_nonce_o, active_count_o};
        if (expected_replies.size() == 0) begin
          $error("result beat with nothing expected");
          failed = 1'b1;
        end else begin
          exp = expected_replies.pop_front();
          if (got.ok !== exp.ok) begin
            $error("ok exp %0h got %0h", exp.ok, got.ok); failed = 1'b1; end
          if (got.found !== exp.found) begin
            $error("found exp %0h got %0h", exp.found, got.found); failed = 1'b1; end
          if (got.slot_index !== exp.slot_index) begin
            $error("slot_index exp %0h got %0h", exp.slot_index, got.slot_index);
            failed = 1'b1;
          end
          if (got.slot_state !== exp.slot_state) begin
            $error("slot_state exp %0h got %0h", exp.slot_state, got.slot_state);
            failed = 1'b1;
          end
          if (got.round_trip !== exp.round_trip) begin
            $error("round_trip exp %0h got %0h", exp.round_trip, got.round_trip);
            failed = 1'b1;
          end
          if (got.timed_out !== exp.timed_out) begin
            $error("timed_out exp %0h got %0h", exp.timed_out, got.timed_out);
            failed = 1'b1;
          end
          if (got.needs_ping !== exp.needs_ping) begin
            $error("needs_ping exp %0h got %0h", exp.needs_ping, got.needs_ping);
            failed = 1'b1;
          end
          if (got.stored_nonce !== exp.stored_nonce) begin
            $error("stored_nonce exp %0h got %0h", exp.stored_nonce, got.stored_nonce);
            failed = 1'b1;
          end
          if (got.active_count !== exp.active_count) begin
            $error("active_count exp %0h got %0h", exp.active_count, got.active_count);
            failed = 1'b1;
          end
        end
      end
      // a stretch of full throughput now and then
      if (out_hold) out_ready_i <= 1'b1;
      else out_ready_i <= (pick_gap() == 0);
      if ($urandom_range(0, 199) == 0) out_hold = ~out_hold;
    end
  end

  // one write cycle, then the write strobe drops before the next write so back to back writes never collide
  task automatic write_reg(reg_e idx, logic [TW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SLOT_LIMIT:    sh_slot_limit = val[CW-1:0];
      REG_TIMEOUT_LIMIT: sh_timeout = val;
      default:           sh_interval = val;
    endcase
    @(posedge clk_i);
  endtask

  // drive one request beat, predict at acceptance; optional typed-in reply
  // valid stays high after acceptance until the next gap, the mid-phase hold or drain drops it
  task automatic send_beat(request_t rq, bit gap, bit has_fixed, reply_t fixed);
    reply_t pred;
    int g;
    g = gap ? pick_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= rq.op;
    peer_id_i <= rq.peer_id;
    time_now_i <= rq.time_now;
    nonce_i <= rq.nonce;
    new_state_i <= rq.new_state;
    do @(posedge clk_i); while (!in_ready_o);
    pred = table_step(rq);
    if (has_fixed && pred !== fixed) begin
      $error("directed row disagrees with table prediction");
      failed = 1'b1;
    end
    expected_replies.push_back(pred);
  endtask

  // wait until every result has come, then let the pipe drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // random request biased toward a small window of ids and coherent times
  function automatic request_t random_request(int id_hi, logic [TW-1:0] base);
    request_t rq;
    int p;
    p = $urandom_range(0, 99);
    rq.op = (p < 3) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    rq.peer_id = ($urandom_range(0, 9) == 0) ? IDW'($urandom_range(0, 63))
                                             : IDW'($urandom_range(0, id_hi));
    case ($urandom_range(0, 9))
      0: rq.time_now = TW'({$urandom, $urandom});
      1: rq.time_now = (p & 1) ? '1 : '0;
      default: rq.time_now = base + $urandom_range(0, 40000) - 2000;
    endcase
    rq.nonce = $urandom;
    rq.new_state = 2'($urandom_range(0, 3));
    return rq;
  endfunction

  // directed rows: op, id, time, nonce, state, whether the reply is typed in
  typedef struct {
    request_t rq;
    bit       fixed;
    reply_t   rp;
  } row_t;

  row_t rows[$];

  initial begin
    logic [TW-1:0] now;
    request_t rq;
    int id_hi;
    for (int i = 0; i < SLOTS; i++) wipe_slot(i);
    sh_active = '0;
    sh_slot_limit = SLOT_LIMIT_RST;
    sh_timeout = TIMEOUT_LIMIT_RST;
    sh_interval = PING_INTERVAL_RST;

    // query and find free after reset, add, busy add, remove of a free slot, out of range ops, set state, pings, pongs
    rows.push_back('{'{OP_QUERY, 6'd63, '0, '0, 2'd0}, 1,
                     '{1, 0, 6'd63, ST_FREE, '0, 0, 0, '0, 7'd0}});
    rows.push_back('{'{OP_FIND, 6'd5, '0, '0, 2'd0}, 1,
                     '{1, 1, 6'd0, ST_FREE, '0, 0, 0, '0, 7'd0}});
    rows.push_back('{'{OP_ADD, 6'd0, '0, '0, 2'd0}, 1,
                     '{1, 0, 6'd0, ST_CONNECTING, '0, 0, 0, '0, 7'd1}});
    rows.push_back('{'{OP_ADD, 6'd0, '0, '0, 2'd0}, 1,
                     '{0, 0, 6'd0, ST_CONNECTING, '0, 0, 0, '0, 7'd1}});
    rows.push_back('{'{OP_REMOVE, 6'd9, '0, '0, 2'd0}, 1,
                     '{0, 0, 6'd9, ST_FREE, '0, 0, 0, '0, 7'd1}});
    rows.push_back('{'{OP_FIND, 6'd0, '0, '0, 2'd0}, 1,
                     '{1, 1, 6'd1, ST_FREE, '0, 0, 0, '0, 7'd1}});
    rows.push_back('{'{4'd12, 6'd0, '1, '1, 2'd3}, 1,
                     '{0, 0, 6'd0, ST_FREE, '0, 0, 0, '0, 7'd1}});
    rows.push_back('{'{4'd15, 6'd63, '1, '1, 2'd3}, 1,
                     '{0, 0, 6'd63, ST_FREE, '0, 0, 0, '0, 7'd1}});
    rows.push_back('{'{OP_SET, 6'd0, '0, '0, 2'd3}, 1,
                     '{0, 0, 6'd0, ST_CONNECTING, '0, 0, 0, '0, 7'd1}});
    rows.push_back('{'{OP_SET, 6'd0, '0, '0, 2'd2}, 0, '0});
    // connected, never pinged: ping due
    rows.push_back('{'{OP_CHECK, 6'd0, 48'd10, '0, 2'd0}, 1,
                     '{1, 0, 6'd0, ST_CONNECTED, '0, 0, 1, '0, 7'd1}});
    rows.push_back('{'{OP_ACTIVITY, 6'd0, 48'd1000, '0, 2'd0}, 0, '0});
    rows.push_back('{'{OP_PING, 6'd0, 48'd2000, 32'hffffffff, 2'd0}, 0, '0});
    // early pong
    rows.push_back('{'{OP_PONG, 6'd0, 48'd1999, '0, 2'd0}, 1,
                     '{0, 0, 6'd0, ST_CONNECTED, '0, 0, 0, 32'hffffffff, 7'd1}});
    rows.push_back('{'{OP_PONG, 6'd0, 48'd2050, '0, 2'd0}, 0, '0});
    // pong far later: truncated difference
    rows.push_back('{'{OP_PONG, 6'd0, '1, '0, 2'd0}, 0, '0});
    rows.push_back('{'{OP_QUERY, 6'd0, '0, '0, 2'd0}, 0, '0});
    // clock backwards and far future
    rows.push_back('{'{OP_CHECK, 6'd0, 48'd500, '0, 2'd0}, 0, '0});
    rows.push_back('{'{OP_CHECK, 6'd0, 48'd31001, '0, 2'd0}, 0, '0});
    rows.push_back('{'{OP_CHECK, 6'd0, 48'd7000, '0, 2'd0}, 0, '0});
    rows.push_back('{'{OP_CHECK, 6'd0, '1, '0, 2'd0}, 0, '0});
    rows.push_back('{'{OP_SET, 6'd0, '0, '0, 2'd0}, 0, '0});
    rows.push_back('{'{OP_REMOVE, 6'd0, '0, '0, 2'd0}, 0, '0});
    rows.push_back('{'{OP_REMOVE, 6'd0, '0, '0, 2'd0}, 0, '0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_beat(rows[i].rq, 1'b1, rows[i].fixed, rows[i].rp);
    drain();

    // limit 0: every id rejected and no free slot found
    // slot 0 went free through set state, so the count still holds one
    write_reg(REG_SLOT_LIMIT, 48'd0);
    write_reg(REG_TIMEOUT_LIMIT, '0);
    write_reg(REG_PING_INTERVAL, '0);
    rq = '{OP_FIND, 6'd3, '0, '0, 2'd0};
    send_beat(rq, 1'b0, 1'b1, '{0, 0, 6'd0, ST_FREE, '0, 0, 0, '0, 7'd1});
    rq = '{OP_ADD, 6'd0, '0, '0, 2'd0};
    send_beat(rq, 1'b0, 1'b1, '{0, 0, 6'd0, ST_FREE, '0, 0, 0, '0, 7'd1});
    drain();

    // fill a small table so find free runs out
    write_reg(REG_SLOT_LIMIT, 48'd3);
    for (int i = 0; i < 4; i++) begin
      rq = '{OP_ADD, IDW'(i), '0, '0, 2'd0};
      send_beat(rq, 1'b1, 1'b0, '0);
    end
    rq = '{OP_FIND, 6'd0, '0, '0, 2'd0};
    send_beat(rq, 1'b1, 1'b1, '{0, 0, 6'd0, ST_FREE, '0, 0, 0, '0, 7'd4});
    drain();

    // random phases with various register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_SLOT_LIMIT, 48'd64); write_reg(REG_TIMEOUT_LIMIT, 48'd30000);
                 write_reg(REG_PING_INTERVAL, 48'd5000); end
        1: begin write_reg(REG_SLOT_LIMIT, 48'd8); write_reg(REG_TIMEOUT_LIMIT, 48'd100);
                 write_reg(REG_PING_INTERVAL, 48'd50); end
        2: begin write_reg(REG_SLOT_LIMIT, 48'd127); write_reg(REG_TIMEOUT_LIMIT, '1);
                 write_reg(REG_PING_INTERVAL, '1); end
        3: begin write_reg(REG_SLOT_LIMIT, 48'd1); write_reg(REG_TIMEOUT_LIMIT, '0);
                 write_reg(REG_PING_INTERVAL, '0); end
        4: begin write_reg(REG_SLOT_LIMIT, 48'd16);
                 write_reg(REG_TIMEOUT_LIMIT, TW'($urandom_range(0, 20000)));
                 write_reg(REG_PING_INTERVAL, TW'($urandom_range(0, 20000))); end
        default: begin write_reg(REG_SLOT_LIMIT, 48'd65);
                 write_reg(REG_TIMEOUT_LIMIT, 48'd30000);
                 write_reg(REG_PING_INTERVAL, 48'd5000); end
      endcase
      id_hi = (ph == 1 || ph == 3) ? 9 : 15;
      now = TW'({$urandom, $urandom});
      for (int n = 0; n < 180; n++) begin
        rq = random_request(id_hi, now);
        now = now + $urandom_range(0, 3000);
        send_beat(rq, 1'b1, 1'b0, '0);
        // hold off until the table has answered everything
        if (n == 90) begin
          in_valid_i <= 1'b0;
          while (expected_replies.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (!failed) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
